// ----- src/fcomp_pkg.sv -----
// package: widths, microcode encoding and the microcode program of the compensator
`timescale 1ns / 1ps

package fcomp_pkg;

  localparam int TEMP_W     = 14;
  localparam int POS_W      = 20;
  localparam int SUM_W      = 21;
  localparam int DELTA_W    = 15;
  localparam int PROD_W     = 24;
  localparam int STEP_W     = 17;
  localparam int DIVD_W     = 22;
  localparam int DIVS_W     = 7;
  localparam int DIV_STEPS  = DIVD_W / 2;
  localparam int DIV_CNT_W  = 4;
  localparam int PC_W       = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int SPD_W      = 9;
  localparam int HYST_W     = 10;
  localparam int COUNT_W    = 7;

  localparam logic [DIVS_W-1:0] CENTI_PER_DEG = 7'd100;

  // reciprocal of 100 scaled by 2^28, exact for dividends below 2^22
  localparam int RECIP_W     = 22;
  localparam int RECIP_SHIFT = 28;
  localparam int SCALE_W     = DIVD_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_CENTI = 22'd2684355;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COMP_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_DEG = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_POSITION = 3'd4;

  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_CHECK,
    OP_DIV,
    OP_MEAN,
    OP_MUL,
    OP_SETUP,
    OP_SCALE,
    OP_MOVE,
    OP_EMIT
  } uop_t;

  typedef enum logic [2:0] {
    CND_NEVER,
    CND_ALWAYS,
    CND_NO_INPUT,
    CND_SKIP,
    CND_DIV_MORE,
    CND_NO_REF,
    CND_INSIDE_HYST,
    CND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    uop_t  op;
    cond_t cond;
    pc_t   target;
  } ucode_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

  // program addresses
  localparam pc_t P_WAIT  = 4'd0;
  localparam pc_t P_CHECK = 4'd1;
  localparam pc_t P_DIV1  = 4'd2;
  localparam pc_t P_MEAN  = 4'd3;
  localparam pc_t P_MUL   = 4'd4;
  localparam pc_t P_SETUP = 4'd5;
  localparam pc_t P_SCALE = 4'd6;
  localparam pc_t P_MOVE  = 4'd7;
  localparam pc_t P_EMIT  = 4'd8;
  localparam pc_t P_RET   = 4'd9;

  function automatic ucode_t ucode_rom(input pc_t pc);
    ucode_t w;
    case (pc)
      P_WAIT:  w = '{op: OP_LOAD,  cond: CND_NO_INPUT,    target: P_WAIT};
      P_CHECK: w = '{op: OP_CHECK, cond: CND_SKIP,        target: P_EMIT};
      P_DIV1:  w = '{op: OP_DIV,   cond: CND_DIV_MORE,    target: P_DIV1};
      P_MEAN:  w = '{op: OP_MEAN,  cond: CND_NO_REF,      target: P_EMIT};
      P_MUL:   w = '{op: OP_MUL,   cond: CND_INSIDE_HYST, target: P_EMIT};
      P_SETUP: w = '{op: OP_SETUP, cond: CND_NEVER,       target: P_WAIT};
      P_SCALE: w = '{op: OP_SCALE, cond: CND_NEVER,       target: P_WAIT};
      P_MOVE:  w = '{op: OP_MOVE,  cond: CND_NEVER,       target: P_WAIT};
      P_EMIT:  w = '{op: OP_EMIT,  cond: CND_OUT_BUSY,    target: P_EMIT};
      P_RET:   w = '{op: OP_NOP,   cond: CND_ALWAYS,      target: P_WAIT};
      default: w = '{op: OP_NOP,   cond: CND_ALWAYS,      target: P_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ----- src/fcomp_if.sv -----
// interfaces: sample channel and result channel
`timescale 1ns / 1ps

interface fcomp_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [fcomp_pkg::TEMP_W-1:0] temperature_centi;
  logic        [fcomp_pkg::POS_W-1:0]  current_position;

  modport source(output valid, output temperature_centi, output current_position, input ready);
  modport sink(input valid, input temperature_centi, input current_position, output ready);
endinterface

interface fcomp_out_if;
  logic                                valid;
  logic                                ready;
  logic                                mean_valid;
  logic signed [fcomp_pkg::TEMP_W-1:0] mean_centi;
  logic                                move_valid;
  logic        [fcomp_pkg::POS_W-1:0]  target_position;

  modport source(output valid, output mean_valid, output mean_centi, output move_valid,
                 output target_position, input ready);
  modport sink(input valid, input mean_valid, input mean_centi, input move_valid,
               input target_position, output ready);
endinterface

// ----- src/fcomp_div.sv -----
// unsigned restoring divider, two quotient bits per step
`timescale 1ns / 1ps

module fcomp_div (
  input  logic                               clk,
  input  logic                               rst,
  input  fcomp_pkg::div_ctrl_t               ctrl,
  input  logic [fcomp_pkg::DIVD_W-1:0]       dividend,
  input  logic [fcomp_pkg::DIVS_W-1:0]       divisor,
  output logic [fcomp_pkg::DIVD_W-1:0]       quotient,
  output logic                               last
);

  logic [fcomp_pkg::DIVS_W-1:0]    rem;
  logic [fcomp_pkg::DIVS_W-1:0]    rem_next;
  logic [fcomp_pkg::DIVD_W-1:0]    quo;
  logic [fcomp_pkg::DIVD_W-1:0]    quo_next;
  logic [fcomp_pkg::DIVS_W-1:0]    dsr;
  logic [fcomp_pkg::DIV_CNT_W-1:0] cnt;
  logic [fcomp_pkg::DIVS_W:0]      t1;
  logic [fcomp_pkg::DIVS_W:0]      t2;
  logic [fcomp_pkg::DIVS_W-1:0]    r1;
  logic                            b1;
  logic                            b2;

  always_comb begin
    t1 = {rem, quo[fcomp_pkg::DIVD_W-1]};
    b1 = (t1 >= {1'b0, dsr});
    r1 = b1 ? fcomp_pkg::DIVS_W'(t1 - {1'b0, dsr}) : t1[fcomp_pkg::DIVS_W-1:0];
    t2 = {r1, quo[fcomp_pkg::DIVD_W-2]};
    b2 = (t2 >= {1'b0, dsr});
    rem_next = b2 ? fcomp_pkg::DIVS_W'(t2 - {1'b0, dsr}) : t2[fcomp_pkg::DIVS_W-1:0];
    quo_next = {quo[fcomp_pkg::DIVD_W-3:0], b1, b2};
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (ctrl.step) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctrl.load) begin
      cnt <= '0;
    end else if (ctrl.step) begin
      cnt <= cnt + 1'b1;
    end
  end

  assign quotient = quo;
  assign last     = (cnt == fcomp_pkg::DIV_CNT_W'(fcomp_pkg::DIV_STEPS - 1));

endmodule

// ----- src/focus_temperature_compensator.sv -----
// top level: microcoded focus temperature compensator
//
// sample channel (valid/ready) takes one transaction per poll tick: a
// temperature in hundredths of a degree and the focuser position.
// result channel gives exactly one transaction per sample: mean flag and
// value, move flag and clamped target position.
// configuration: cfg_write, cfg_index, cfg_data write one register per cycle.
// a small microcode program steps a shared datapath; its path for a sample
// depends on whether the sample is only accumulated or gives a mean that
// sets the reference, a mean inside the hysteresis or a mean with a move;
// the longer paths are set mostly by the divider for the mean (two
// quotient bits per cycle, 11 steps); the move scales by a reciprocal
// multiply in one step.
// ready is high only on the wait step of the program.
// the result sits in an output register; the program waits on the emit
// step while an earlier result is still not taken, so a stalled receiver
// holds the sample channel off.
// reset clears configuration to its defaults, the sum, count and reference,
// and leaves the result channel empty.
`timescale 1ns / 1ps

module focus_temperature_compensator (
  input  logic                                 clk,
  input  logic                                 rst,
  fcomp_in_if.sink                             sample,
  fcomp_out_if.source                          result,
  input  logic                                 cfg_write,
  input  logic [fcomp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fcomp_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // configuration
  logic                                comp_enable;
  logic signed [fcomp_pkg::SPD_W-1:0]  steps_per_degree;
  logic [fcomp_pkg::HYST_W-1:0]        hysteresis_centi;
  logic [fcomp_pkg::COUNT_W-1:0]       sample_count;
  logic [fcomp_pkg::POS_W-1:0]         max_position;

  // state
  logic [fcomp_pkg::COUNT_W-1:0]       tick_count;
  logic signed [fcomp_pkg::SUM_W-1:0]  temp_sum;
  logic signed [fcomp_pkg::TEMP_W-1:0] ref_mean;
  logic                                ref_valid;

  // sequencer
  fcomp_pkg::pc_t    pc;
  fcomp_pkg::pc_t    pc_next;
  fcomp_pkg::ucode_t uc;
  logic              cond_true;

  // datapath
  logic signed [fcomp_pkg::TEMP_W-1:0]  temp_r;
  logic [fcomp_pkg::POS_W-1:0]          pos_r;
  logic signed [fcomp_pkg::DELTA_W-1:0] delta;
  logic signed [fcomp_pkg::PROD_W-1:0]  prod;
  logic                                 neg;
  logic [fcomp_pkg::DIVD_W-1:0]         mag_prod;
  logic [fcomp_pkg::STEP_W-1:0]         scaled;
  logic                                 res_mean_valid;
  logic signed [fcomp_pkg::TEMP_W-1:0]  res_mean;
  logic                                 res_move_valid;
  logic [fcomp_pkg::POS_W-1:0]          res_target;
  logic                                 out_valid;
  logic                                 out_mean_valid;
  logic signed [fcomp_pkg::TEMP_W-1:0]  out_mean;
  logic                                 out_move_valid;
  logic [fcomp_pkg::POS_W-1:0]          out_target;

  logic [fcomp_pkg::COUNT_W-1:0]        n;
  logic                                 accumulating;
  logic                                 skip;
  logic                                 accept;
  logic                                 out_busy;
  logic                                 emit_fire;
  logic signed [fcomp_pkg::DIVD_W-1:0]  sum_ext;
  logic [fcomp_pkg::DIVD_W-1:0]         abs_sum;
  logic signed [fcomp_pkg::PROD_W-1:0]  prod_neg;
  logic [fcomp_pkg::DIVD_W-1:0]         abs_prod;
  logic [fcomp_pkg::SCALE_W-1:0]        scale_prod;
  logic signed [fcomp_pkg::TEMP_W-1:0]  mean;
  logic signed [fcomp_pkg::STEP_W-1:0]  steps;
  logic signed [fcomp_pkg::DELTA_W-1:0] delta_neg;
  logic [fcomp_pkg::DELTA_W-1:0]        mag;
  logic signed [fcomp_pkg::DIVD_W-1:0]  sum_pos;
  logic [fcomp_pkg::POS_W-1:0]          clamped;

  fcomp_pkg::div_ctrl_t                 div_ctrl;
  logic [fcomp_pkg::DIVD_W-1:0]         div_dividend;
  logic [fcomp_pkg::DIVS_W-1:0]         div_divisor;
  logic [fcomp_pkg::DIVD_W-1:0]         div_quotient;
  logic                                 div_last;

  fcomp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .last     (div_last)
  );

  // shared arithmetic
  always_comb begin
    n            = (sample_count == '0) ? fcomp_pkg::COUNT_W'(1) : sample_count;
    accumulating = (tick_count < n);
    skip         = !comp_enable || accumulating;
    sum_ext      = {{(fcomp_pkg::DIVD_W - fcomp_pkg::SUM_W){temp_sum[fcomp_pkg::SUM_W-1]}},
                    temp_sum};
    abs_sum      = sum_ext[fcomp_pkg::DIVD_W-1] ? fcomp_pkg::DIVD_W'(-sum_ext) : sum_ext;
    prod_neg     = -prod;
    abs_prod     = prod[fcomp_pkg::PROD_W-1] ? prod_neg[fcomp_pkg::DIVD_W-1:0]
                                               : prod[fcomp_pkg::DIVD_W-1:0];
    scale_prod   = fcomp_pkg::SCALE_W'(mag_prod) * fcomp_pkg::SCALE_W'(fcomp_pkg::RECIP_CENTI);
    mean         = neg ? -$signed(div_quotient[fcomp_pkg::TEMP_W-1:0])
                       : $signed(div_quotient[fcomp_pkg::TEMP_W-1:0]);
    steps        = neg ? -$signed(scaled) : $signed(scaled);
    delta_neg    = -delta;
    mag          = delta[fcomp_pkg::DELTA_W-1] ? delta_neg : delta;
    sum_pos      = $signed({2'b00, pos_r})
                 + {{(fcomp_pkg::DIVD_W - fcomp_pkg::STEP_W){steps[fcomp_pkg::STEP_W-1]}}, steps};
    if (sum_pos[fcomp_pkg::DIVD_W-1]) begin
      clamped = '0;
    end else if (sum_pos[fcomp_pkg::DIVD_W-2:0] > {1'b0, max_position}) begin
      clamped = max_position;
    end else begin
      clamped = sum_pos[fcomp_pkg::POS_W-1:0];
    end
  end

  // microcode fetch and branch condition
  always_comb begin
    uc       = fcomp_pkg::ucode_rom(pc);
    out_busy = out_valid && !result.ready;
    case (uc.cond)
      fcomp_pkg::CND_NEVER:       cond_true = 1'b0;
      fcomp_pkg::CND_ALWAYS:      cond_true = 1'b1;
      fcomp_pkg::CND_NO_INPUT:    cond_true = !sample.valid;
      fcomp_pkg::CND_SKIP:        cond_true = skip;
      fcomp_pkg::CND_DIV_MORE:    cond_true = !div_last;
      fcomp_pkg::CND_NO_REF:      cond_true = !ref_valid;
      fcomp_pkg::CND_INSIDE_HYST: cond_true = (mag <= {{(fcomp_pkg::DELTA_W
                                                  - fcomp_pkg::HYST_W){1'b0}},
                                                  hysteresis_centi});
      fcomp_pkg::CND_OUT_BUSY:    cond_true = out_busy;
      default:                    cond_true = 1'b1;
    endcase
  end

  // next step
  always_comb begin
    pc_next = cond_true ? uc.target : fcomp_pkg::pc_t'(pc + 1'b1);
  end

  // control word decode
  always_comb begin
    sample.ready  = (uc.op == fcomp_pkg::OP_LOAD);
    accept        = sample.valid && sample.ready;
    emit_fire     = (uc.op == fcomp_pkg::OP_EMIT) && !out_busy;
    div_ctrl.load = (uc.op == fcomp_pkg::OP_CHECK);
    div_ctrl.step = (uc.op == fcomp_pkg::OP_DIV);
    div_dividend  = abs_sum;
    div_divisor   = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= fcomp_pkg::P_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

  // configuration and accumulator state
  always_ff @(posedge clk) begin
    if (rst) begin
      comp_enable      <= 1'b0;
      steps_per_degree <= '0;
      hysteresis_centi <= fcomp_pkg::HYST_W'(100);
      sample_count     <= fcomp_pkg::COUNT_W'(5);
      max_position     <= '1;
      tick_count       <= '0;
      temp_sum         <= '0;
      ref_mean         <= '0;
      ref_valid        <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          fcomp_pkg::REG_COMP_ENABLE: begin
            comp_enable <= cfg_data[0];
            if (!cfg_data[0]) begin
              tick_count <= '0;
              temp_sum   <= '0;
            end
          end
          fcomp_pkg::REG_STEPS_PER_DEG: begin
            steps_per_degree <= $signed(cfg_data[fcomp_pkg::SPD_W-1:0]);
            tick_count       <= '0;
            temp_sum         <= '0;
            ref_valid        <= 1'b0;
          end
          fcomp_pkg::REG_HYSTERESIS: begin
            hysteresis_centi <= cfg_data[fcomp_pkg::HYST_W-1:0];
            tick_count       <= '0;
            temp_sum         <= '0;
            ref_valid        <= 1'b0;
          end
          fcomp_pkg::REG_SAMPLE_COUNT: begin
            sample_count <= cfg_data[fcomp_pkg::COUNT_W-1:0];
            tick_count   <= '0;
            temp_sum     <= '0;
            ref_valid    <= 1'b0;
          end
          fcomp_pkg::REG_MAX_POSITION: begin
            max_position <= cfg_data[fcomp_pkg::POS_W-1:0];
          end
          default: begin
          end
        endcase
      end
      case (uc.op)
        fcomp_pkg::OP_CHECK: begin
          if (comp_enable && accumulating) begin
            tick_count <= tick_count + 1'b1;
            temp_sum   <= temp_sum
                        + {{(fcomp_pkg::SUM_W - fcomp_pkg::TEMP_W){temp_r[fcomp_pkg::TEMP_W-1]}},
                           temp_r};
          end
        end
        fcomp_pkg::OP_MEAN: begin
          tick_count <= '0;
          temp_sum   <= '0;
          if (!ref_valid) begin
            ref_mean  <= mean;
            ref_valid <= 1'b1;
          end
        end
        fcomp_pkg::OP_SETUP: begin
          ref_mean <= res_mean;
        end
        default: begin
        end
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (uc.op)
      fcomp_pkg::OP_LOAD: begin
        if (accept) begin
          temp_r         <= sample.temperature_centi;
          pos_r          <= sample.current_position;
          res_mean_valid <= 1'b0;
          res_mean       <= '0;
          res_move_valid <= 1'b0;
          res_target     <= '0;
        end
      end
      fcomp_pkg::OP_CHECK: begin
        neg <= temp_sum[fcomp_pkg::SUM_W-1];
      end
      fcomp_pkg::OP_MEAN: begin
        res_mean_valid <= 1'b1;
        res_mean       <= mean;
        delta          <= fcomp_pkg::DELTA_W'(mean) - fcomp_pkg::DELTA_W'(ref_mean);
      end
      fcomp_pkg::OP_MUL: begin
        prod <= fcomp_pkg::PROD_W'(delta) * fcomp_pkg::PROD_W'(steps_per_degree);
      end
      fcomp_pkg::OP_SETUP: begin
        neg      <= prod[fcomp_pkg::PROD_W-1];
        mag_prod <= abs_prod;
      end
      fcomp_pkg::OP_SCALE: begin
        scaled <= {1'b0, scale_prod[fcomp_pkg::RECIP_SHIFT +: fcomp_pkg::STEP_W-1]};
      end
      fcomp_pkg::OP_MOVE: begin
        res_move_valid <= 1'b1;
        res_target     <= clamped;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_mean_valid <= res_mean_valid;
      out_mean       <= res_mean;
      out_move_valid <= res_move_valid;
      out_target     <= res_target;
    end
  end

  assign result.valid           = out_valid;
  assign result.mean_valid      = out_mean_valid;
  assign result.mean_centi      = out_mean;
  assign result.move_valid      = out_move_valid;
  assign result.target_position = out_target;

  a_move_has_mean: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.move_valid |-> result.mean_valid)
    else $error("move without a mean");

  a_zero_mean_when_none: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.mean_valid |-> (result.mean_centi == '0))
    else $error("mean field not zero without a mean");

  a_target_clamped: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.move_valid |-> (result.target_position <= max_position))
    else $error("target above clamp limit");

  a_one_sample_at_a_time: assert property (@(posedge clk) disable iff (rst)
    sample.valid && sample.ready |=> !sample.ready)
    else $error("second sample taken while one is in work");

endmodule

// ----- sim/focus_temperature_compensator_test.sv -----
// testbench: compensator driven with directed and random ticks, each transaction checked
`timescale 1ns / 1ps

module focus_temperature_compensator_test;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 870;
  localparam int TEMP_LO      = -5000;
  localparam int TEMP_HI      = 7000;
  localparam int POS_MAX      = (1 << fcomp_pkg::POS_W) - 1;
  localparam int SPD_MAX      = 200;
  localparam int HYST_MAX     = 1000;
  localparam int COUNT_MAX    = 120;
  localparam int PRINT_LIMIT  = 30;

  localparam logic [fcomp_pkg::CFG_IDX_W-1:0] REG_UNUSED_FIRST =
    fcomp_pkg::REG_MAX_POSITION + 3'd1;
  localparam logic [fcomp_pkg::CFG_IDX_W-1:0] REG_UNUSED_LAST  = '1;

  typedef struct packed {
    logic                                mean_valid;
    logic signed [fcomp_pkg::TEMP_W-1:0] mean_centi;
    logic                                move_valid;
    logic [fcomp_pkg::POS_W-1:0]         target_position;
  } tick_result_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic [fcomp_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [fcomp_pkg::CFG_DATA_W-1:0] cfg_data;

  fcomp_in_if  sample_ch();
  fcomp_out_if result_ch();

  focus_temperature_compensator dut (
    .clk(clk),
    .rst(rst),
    .sample(sample_ch),
    .result(result_ch),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // compensator copy: configuration
  logic                               comp_on   = 1'b0;
  logic signed [fcomp_pkg::SPD_W-1:0] spd       = '0;
  logic [fcomp_pkg::HYST_W-1:0]       hyst_lim  = 10'd100;
  logic [fcomp_pkg::COUNT_W-1:0]      n_samples = 7'd5;
  logic [fcomp_pkg::POS_W-1:0]        pos_limit = '1;

  // compensator copy: accumulator and reference
  int acc_ticks = 0;
  int acc_sum   = 0;
  int base_mean = 0;
  bit base_set  = 1'b0;

  tick_result_t pending_results[$];

  int  mismatch_count = 0;
  int  results_seen   = 0;
  int  cycle_count    = 0;
  int  hold_off       = 0;
  bit  idle_on        = 1'b1;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("focus_temperature_compensator_test failed");
      $finish;
    end
  end

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 93) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      hold_off = 0;
    end else if (hold_off > 0) begin
      result_ch.ready <= 1'b0;
      hold_off--;
    end else if (idle_on && $urandom_range(0, 99) < 8) begin
      result_ch.ready <= 1'b0;
      hold_off = gap_length() - 1;
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("mismatch on result %0d: %s got %0d expected %0d", results_seen, what, got, want);
  endtask

  always @(posedge clk) begin : check_results
    tick_result_t want;
    if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("transaction with nothing pending", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (result_ch.mean_valid !== want.mean_valid)
          report_mismatch("mean_valid", result_ch.mean_valid, want.mean_valid);
        if (result_ch.mean_centi !== want.mean_centi)
          report_mismatch("mean_centi", result_ch.mean_centi, want.mean_centi);
        if (result_ch.move_valid !== want.move_valid)
          report_mismatch("move_valid", result_ch.move_valid, want.move_valid);
        if (result_ch.target_position !== want.target_position)
          report_mismatch("target_position", result_ch.target_position, want.target_position);
      end
      results_seen++;
    end
  end

  task automatic compensate_tick(input logic signed [fcomp_pkg::TEMP_W-1:0] temp,
                                 input logic [fcomp_pkg::POS_W-1:0] pos);
    int           n;
    int           mean;
    int           delta;
    int           mag;
    longint       steps;
    longint       tgt;
    tick_result_t r;
    r = '0;
    n = (n_samples == 0) ? 1 : int'(n_samples);
    if (comp_on) begin
      if (acc_ticks < n) begin
        acc_ticks++;
        acc_sum += temp;
      end else begin
        mean = acc_sum / n;
        r.mean_valid = 1'b1;
        r.mean_centi = mean[fcomp_pkg::TEMP_W-1:0];
        if (!base_set) begin
          base_mean = mean;
          base_set  = 1'b1;
        end else begin
          delta = mean - base_mean;
          mag   = (delta < 0) ? -delta : delta;
          if (mag > int'(hyst_lim)) begin
            steps = (longint'(delta) * longint'(spd)) / int'(fcomp_pkg::CENTI_PER_DEG);
            tgt   = longint'(pos) + steps;
            if (tgt > longint'(pos_limit)) tgt = longint'(pos_limit);
            if (tgt < 0) tgt = 0;
            r.move_valid      = 1'b1;
            r.target_position = tgt[fcomp_pkg::POS_W-1:0];
            base_mean = mean;
          end
        end
        acc_ticks = 0;
        acc_sum   = 0;
      end
    end
    pending_results = {pending_results, r};
  endtask

  task automatic write_reg(input logic [fcomp_pkg::CFG_IDX_W-1:0] idx, input int data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data[fcomp_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    case (idx)
      fcomp_pkg::REG_COMP_ENABLE: begin
        comp_on = data[0];
        if (!data[0]) begin
          acc_sum   = 0;
          acc_ticks = 0;
        end
      end
      fcomp_pkg::REG_STEPS_PER_DEG: begin
        spd = data[fcomp_pkg::SPD_W-1:0];
        acc_sum = 0; acc_ticks = 0; base_set = 1'b0;
      end
      fcomp_pkg::REG_HYSTERESIS: begin
        hyst_lim = data[fcomp_pkg::HYST_W-1:0];
        acc_sum = 0; acc_ticks = 0; base_set = 1'b0;
      end
      fcomp_pkg::REG_SAMPLE_COUNT: begin
        n_samples = data[fcomp_pkg::COUNT_W-1:0];
        acc_sum = 0; acc_ticks = 0; base_set = 1'b0;
      end
      fcomp_pkg::REG_MAX_POSITION: pos_limit = data[fcomp_pkg::POS_W-1:0];
      default: ;
    endcase
    cfg_write <= 1'b0;
  endtask

  task automatic send_sample(input int temp, input int pos);
    int gap;
    gap = (idle_on && $urandom_range(0, 99) < 40) ? gap_length() : 0;
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid             <= 1'b1;
    sample_ch.temperature_centi <= temp[fcomp_pkg::TEMP_W-1:0];
    sample_ch.current_position  <= pos[fcomp_pkg::POS_W-1:0];
    @(posedge clk);
    while (sample_ch.ready !== 1'b1) @(posedge clk);
    compensate_tick(temp[fcomp_pkg::TEMP_W-1:0], pos[fcomp_pkg::POS_W-1:0]);
  endtask

  task automatic wait_idle();
    sample_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_disabled();
    send_sample(1234, 500);
    send_sample(TEMP_LO, POS_MAX);
    wait_idle();
  endtask

  task automatic test_first_mean_and_move();
    write_reg(fcomp_pkg::REG_COMP_ENABLE, 1);
    write_reg(fcomp_pkg::REG_STEPS_PER_DEG, 100);
    write_reg(fcomp_pkg::REG_HYSTERESIS, 0);
    write_reg(fcomp_pkg::REG_SAMPLE_COUNT, 1);
    send_sample(1000, 1000);
    send_sample(0, 1000);
    send_sample(1500, 1000);
    send_sample(0, 1000);
    wait_idle();
  endtask

  task automatic test_hysteresis_edge();
    write_reg(fcomp_pkg::REG_HYSTERESIS, 100);
    send_sample(0, 2000);
    send_sample(0, 2000);
    send_sample(100, 2000);
    send_sample(0, 2000);
    send_sample(201, 2000);
    send_sample(0, 2000);
    wait_idle();
  endtask

  task automatic test_clamps();
    write_reg(fcomp_pkg::REG_STEPS_PER_DEG, SPD_MAX);
    write_reg(fcomp_pkg::REG_MAX_POSITION, 1000);
    send_sample(TEMP_HI, POS_MAX);
    send_sample(0, POS_MAX);
    send_sample(TEMP_LO, 5);
    send_sample(0, 5);
    send_sample(TEMP_HI, POS_MAX);
    send_sample(0, POS_MAX);
    wait_idle();
  endtask

  task automatic test_zero_step_zero_count();
    write_reg(fcomp_pkg::REG_STEPS_PER_DEG, 0);
    write_reg(fcomp_pkg::REG_SAMPLE_COUNT, 0);
    send_sample(200, POS_MAX);
    send_sample(0, POS_MAX);
    send_sample(-300, POS_MAX);
    send_sample(0, POS_MAX);
    wait_idle();
  endtask

  task automatic test_clear_writes();
    write_reg(fcomp_pkg::REG_STEPS_PER_DEG, -SPD_MAX);
    write_reg(fcomp_pkg::REG_SAMPLE_COUNT, 3);
    send_sample(500, 700);
    send_sample(500, 700);
    wait_idle();
    write_reg(fcomp_pkg::REG_COMP_ENABLE, 0);
    write_reg(fcomp_pkg::REG_COMP_ENABLE, 1);
    write_reg(fcomp_pkg::REG_MAX_POSITION, POS_MAX);
    write_reg(REG_UNUSED_FIRST, -1);
    write_reg(REG_UNUSED_LAST, -1);
    send_sample(10, 700);
    send_sample(20, 700);
    send_sample(30, 700);
    send_sample(TEMP_HI, 700);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int  items;
    int  walk;
    int  drift;
    int  n;
    int  len;
    int  t;
    int  p;
    int  en;
    bit  large_done;
    items      = 0;
    walk       = 2000;
    large_done = 1'b0;
    while (items < RANDOM_ITEMS) begin
      wait_idle();
      idle_on = ($urandom_range(0, 3) != 0);
      en = ($urandom_range(0, 9) != 0);
      if (!large_done && items >= RANDOM_ITEMS / 3) en = 1;
      write_reg(fcomp_pkg::REG_COMP_ENABLE, en);
      if ($urandom_range(0, 9) < 4) begin
        case ($urandom_range(0, 5))
          0: write_reg(fcomp_pkg::REG_STEPS_PER_DEG, -SPD_MAX);
          1: write_reg(fcomp_pkg::REG_STEPS_PER_DEG, SPD_MAX);
          2: write_reg(fcomp_pkg::REG_STEPS_PER_DEG, 0);
          default: write_reg(fcomp_pkg::REG_STEPS_PER_DEG,
                             int'($urandom_range(0, 2 * SPD_MAX)) - SPD_MAX);
        endcase
      end
      if ($urandom_range(0, 9) < 3) begin
        case ($urandom_range(0, 4))
          0: write_reg(fcomp_pkg::REG_HYSTERESIS, 0);
          1: write_reg(fcomp_pkg::REG_HYSTERESIS, HYST_MAX);
          default: write_reg(fcomp_pkg::REG_HYSTERESIS, $urandom_range(0, 300));
        endcase
      end
      if (!large_done && items >= RANDOM_ITEMS / 3) begin
        write_reg(fcomp_pkg::REG_SAMPLE_COUNT, COUNT_MAX);
        large_done = 1'b1;
      end else if ($urandom_range(0, 9) < 3) begin
        t = $urandom_range(0, 99);
        if (t < 4)
          write_reg(fcomp_pkg::REG_SAMPLE_COUNT,
                    $urandom_range(0, 1) ? COUNT_MAX : $urandom_range(60, 119));
        else if (t < 12)
          write_reg(fcomp_pkg::REG_SAMPLE_COUNT, 0);
        else
          write_reg(fcomp_pkg::REG_SAMPLE_COUNT, $urandom_range(1, 8));
      end
      if ($urandom_range(0, 9) < 3) begin
        case ($urandom_range(0, 3))
          0: write_reg(fcomp_pkg::REG_MAX_POSITION, 0);
          1: write_reg(fcomp_pkg::REG_MAX_POSITION, POS_MAX);
          default: write_reg(fcomp_pkg::REG_MAX_POSITION, $urandom_range(0, POS_MAX));
        endcase
      end
      n     = (n_samples == 0) ? 1 : int'(n_samples);
      len   = (n > 30) ? 2 * (n + 1) : int'($urandom_range(3, 10)) * (n + 1);
      drift = int'($urandom_range(0, 240)) - 120;
      repeat (len) begin
        if ($urandom_range(0, 99) < 85) begin
          walk = walk + drift + int'($urandom_range(0, 100)) - 50;
          if (walk > TEMP_HI) begin
            walk  = TEMP_HI;
            drift = -drift;
          end
          if (walk < TEMP_LO) begin
            walk  = TEMP_LO;
            drift = -drift;
          end
          t = walk;
        end else begin
          case ($urandom_range(0, 2))
            0: t = TEMP_LO;
            1: t = TEMP_HI;
            default: t = int'($urandom_range(0, TEMP_HI - TEMP_LO)) + TEMP_LO;
          endcase
        end
        case ($urandom_range(0, 9))
          0: p = 0;
          1: p = POS_MAX;
          2: begin
            p = int'(pos_limit) + int'($urandom_range(0, 64)) - 32;
            if (p < 0) p = 0;
            if (p > POS_MAX) p = POS_MAX;
          end
          default: p = $urandom_range(0, POS_MAX);
        endcase
        send_sample(t, p);
        items++;
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst                         <= 1'b1;
    cfg_write                   <= 1'b0;
    cfg_index                   <= '0;
    cfg_data                    <= '0;
    sample_ch.valid             <= 1'b0;
    sample_ch.temperature_centi <= '0;
    sample_ch.current_position  <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_disabled();
    test_first_mean_and_move();
    test_hysteresis_edge();
    test_clamps();
    test_zero_step_zero_count();
    test_clear_writes();
    test_random_traffic();
    wait_idle();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("focus_temperature_compensator_test passed");
    end else begin
      $display("focus_temperature_compensator_test failed");
    end
    $finish;
  end

endmodule
